// ===== src/fird3_pkg.sv =====
// fird3_pkg: shared constants, types and coefficient table for the
// decimating FIR filter. Used by fird3_ctrl, fird3_dp and fir_decimate_by_three.
`timescale 1ns / 1ps
`default_nettype none

package fird3_pkg;

  localparam int TapCount    = 15;
  localparam int DecimFactor = 3;
  localparam int SampleBits  = 16;
  localparam int CoefBits    = 16;
  localparam int CoefFrac    = 15;

  localparam int TapIdxW = (TapCount > 1) ? $clog2(TapCount) : 1;
  localparam int PhaseW  = (DecimFactor > 1) ? $clog2(DecimFactor) : 1;
  localparam int ProdW   = SampleBits + CoefBits;
  localparam int AccW    = ProdW + $clog2(TapCount);
  localparam int ShW     = AccW - CoefFrac;

  typedef enum logic [1:0] {
    StIdle,
    StMac,
    StDrain,
    StOut
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic               shift;
    logic               mul_en;
    logic               acc_clr;
    logic               acc_en;
    logic               out_load;
    logic [TapIdxW-1:0] tap_idx;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_full;
  } status_t;

  // Q0.15 kernel; entry k multiplies the sample TapCount-1-k inputs old
  function automatic logic signed [CoefBits-1:0] coef(input logic [TapIdxW-1:0] idx);
    logic signed [CoefBits-1:0] c;
    case (idx)
      TapIdxW'(0):  c = -CoefBits'(111);
      TapIdxW'(1):  c = -CoefBits'(249);
      TapIdxW'(2):  c = CoefBits'(0);
      TapIdxW'(3):  c = CoefBits'(1160);
      TapIdxW'(4):  c = CoefBits'(2982);
      TapIdxW'(5):  c = CoefBits'(4843);
      TapIdxW'(6):  c = CoefBits'(6141);
      TapIdxW'(7):  c = CoefBits'(6141);
      TapIdxW'(8):  c = CoefBits'(4843);
      TapIdxW'(9):  c = CoefBits'(2982);
      TapIdxW'(10): c = CoefBits'(1160);
      TapIdxW'(11): c = CoefBits'(0);
      TapIdxW'(12): c = -CoefBits'(249);
      TapIdxW'(13): c = -CoefBits'(111);
      default:      c = CoefBits'(0);
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/fir_decimate_by_three.sv =====
// fir_decimate_by_three: 15-tap low-pass FIR decimator by three, top level.
// Depends on fird3_pkg, fird3_ctrl and fird3_dp.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / pcm_sample_i) takes signed Q0.15
//   samples. Output channel (out_valid_o / out_ready_i / filtered_sample_o)
//   gives one Q0.15 sample, rounded and saturated, for every third input
//   transaction, counting the first one after reset as phase 0.
//   A non-emitting input is taken while the controller is idle. An emitting
//   input starts a multiply-accumulate for each of the 15 taps on the single
//   multiplier, then a drain step and a load of the output register; no
//   further input is taken until the controller is idle again.
//   Reset clears the tap line to zero, the phase to 0 and the output valid.
//   When the receiver stalls, the result waits in the output register while
//   inputs keep being taken; the next result waits in the accumulator until
//   the output register is free, and inputs stall meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module fir_decimate_by_three (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic signed [fird3_pkg::SampleBits-1:0] pcm_sample_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic signed [fird3_pkg::SampleBits-1:0]     filtered_sample_o
);

  fird3_pkg::cmd_t    cmd;
  fird3_pkg::status_t status;

  fird3_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fird3_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .pcm_sample_i      (pcm_sample_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .filtered_sample_o (filtered_sample_o)
  );

endmodule

`default_nettype wire

// ===== src/fird3_ctrl.sv =====
// fird3_ctrl: sequencer for the decimating FIR; keeps the decimation phase
// and the tap counter. Depends on fird3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fird3_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire fird3_pkg::status_t status_i,
  output fird3_pkg::cmd_t       cmd_o
);

  fird3_pkg::state_e                 state_q, state_d;
  logic [fird3_pkg::PhaseW-1:0]      phase_q, phase_d;
  logic [fird3_pkg::TapIdxW-1:0]     cnt_q, cnt_d;
  logic                              in_xact;
  logic                              last_tap;

  assign in_xact  = in_valid_i & in_ready_o;
  assign last_tap = (cnt_q == fird3_pkg::TapIdxW'(fird3_pkg::TapCount - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fird3_pkg::StIdle;
      phase_q <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.tap_idx = cnt_q;
    case (state_q)
      fird3_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_xact) begin
          cmd_o.shift = 1'b1;
          if (phase_q == fird3_pkg::PhaseW'(fird3_pkg::DecimFactor - 1)) begin
            phase_d = '0;
            cnt_d   = '0;
            state_d = fird3_pkg::StMac;
          end else begin
            phase_d = phase_q + fird3_pkg::PhaseW'(1);
          end
        end
      end
      fird3_pkg::StMac: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.acc_clr = (cnt_q == '0);
        cmd_o.acc_en  = (cnt_q != '0);
        if (last_tap) begin
          state_d = fird3_pkg::StDrain;
        end else begin
          cnt_d = cnt_q + fird3_pkg::TapIdxW'(1);
        end
      end
      fird3_pkg::StDrain: begin
        cmd_o.acc_en = 1'b1;
        state_d      = fird3_pkg::StOut;
      end
      fird3_pkg::StOut: begin
        if (!status_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = fird3_pkg::StIdle;
        end
      end
      default: begin
        state_d = fird3_pkg::StIdle;
      end
    endcase
  end

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= fird3_pkg::PhaseW'(fird3_pkg::DecimFactor - 1))
    else $error("phase out of range");

  a_emit_starts_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xact && phase_q == fird3_pkg::PhaseW'(fird3_pkg::DecimFactor - 1)
    |=> state_q == fird3_pkg::StMac && cnt_q == '0)
    else $error("emitting transaction did not start MAC");

  a_mac_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fird3_pkg::StMac && last_tap |=> state_q == fird3_pkg::StDrain)
    else $error("MAC did not end after last tap");

  a_no_load_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !status_i.out_full)
    else $error("output register overwritten");

endmodule

`default_nettype wire

// ===== src/fird3_dp.sv =====
// fird3_dp: tap line, single multiplier, accumulator, round/saturate and
// output register for the decimating FIR. Depends on fird3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fird3_dp (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire fird3_pkg::cmd_t                        cmd_i,
  output fird3_pkg::status_t                          status_o,
  input  wire logic signed [fird3_pkg::SampleBits-1:0] pcm_sample_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic signed [fird3_pkg::SampleBits-1:0]     filtered_sample_o
);

  // taps_q[TapCount-1] is the newest sample
  logic signed [fird3_pkg::SampleBits-1:0] taps_q [fird3_pkg::TapCount];
  logic signed [fird3_pkg::ProdW-1:0]      prod_q;
  logic signed [fird3_pkg::AccW-1:0]       acc_q;
  logic signed [fird3_pkg::AccW-1:0]       acc_rnd;
  logic signed [fird3_pkg::ShW-1:0]        sh;
  logic signed [fird3_pkg::SampleBits-1:0] sat;
  logic [fird3_pkg::ShW-fird3_pkg::SampleBits:0] top_bits;
  logic                                    out_valid_q;
  logic signed [fird3_pkg::SampleBits-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fird3_pkg::TapCount; i++) begin
        taps_q[i] <= '0;
      end
    end else if (cmd_i.shift) begin
      for (int i = 0; i < fird3_pkg::TapCount - 1; i++) begin
        taps_q[i] <= taps_q[i+1];
      end
      taps_q[fird3_pkg::TapCount-1] <= pcm_sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= fird3_pkg::coef(cmd_i.tap_idx) * taps_q[cmd_i.tap_idx];
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + fird3_pkg::AccW'(prod_q);
    end
  end

  // round half up, then saturate to the sample range
  assign acc_rnd  = acc_q + fird3_pkg::AccW'(1 << (fird3_pkg::CoefFrac - 1));
  assign sh       = acc_rnd[fird3_pkg::AccW-1:fird3_pkg::CoefFrac];
  assign top_bits = sh[fird3_pkg::ShW-1:fird3_pkg::SampleBits-1];

  always_comb begin
    if ((top_bits == '0) || (top_bits == '1)) begin
      sat = sh[fird3_pkg::SampleBits-1:0];
    end else if (sh[fird3_pkg::ShW-1]) begin
      sat = {1'b1, {(fird3_pkg::SampleBits-1){1'b0}}};
    end else begin
      sat = {1'b0, {(fird3_pkg::SampleBits-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= sat;
    end
  end

  assign status_o.out_full  = out_valid_q & ~out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign filtered_sample_o  = out_q;

endmodule

`default_nettype wire
